@@ rtl/ciq_pkg.sv @@
`timescale 1ns / 1ps

package ciq_pkg;

    localparam int SLOTS      = 8;
    localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W      = $clog2(SLOTS + 1);

    localparam int MODE_W  = 3;
    localparam int PORT_W  = 10;
    localparam int ROB_W   = 5;
    localparam int TAG_W   = 6;
    localparam int RDY_W   = 4;
    localparam int FU_W    = 10;
    localparam int ITYPE_W = 2;
    localparam int PART_W  = 2;
    localparam int GSLOT_W = 3;
    localparam int FREE_W  = 4;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = MODE_W;
    localparam int M_TDATA_W = 32;

    // input beat layout, lowest bit first
    localparam int IN_PORT  = 0;
    localparam int IN_DISP  = IN_PORT + PORT_W;
    localparam int IN_ROB   = IN_DISP + 1;
    localparam int IN_SRC_A = IN_ROB + ROB_W;
    localparam int IN_SRC_B = IN_SRC_A + TAG_W;
    localparam int IN_SRC_C = IN_SRC_B + TAG_W;
    localparam int IN_RDY   = IN_SRC_C + TAG_W;
    localparam int IN_FU    = IN_RDY + RDY_W;
    localparam int IN_SPLIT = IN_FU + FU_W;
    localparam int IN_ITYPE = IN_SPLIT + 1;
    localparam int IN_WTAG  = IN_ITYPE + ITYPE_W;
    localparam int IN_END   = IN_WTAG + TAG_W;

    // result beat layout, lowest bit first
    localparam int OUT_GVALID = 0;
    localparam int OUT_GSLOT  = OUT_GVALID + 1;
    localparam int OUT_GROB   = OUT_GSLOT + GSLOT_W;
    localparam int OUT_GSRC_A = OUT_GROB + ROB_W;
    localparam int OUT_GSRC_B = OUT_GSRC_A + TAG_W;
    localparam int OUT_GPART  = OUT_GSRC_B + TAG_W;
    localparam int OUT_FREE   = OUT_GPART + PART_W;
    localparam int OUT_CANACC = OUT_FREE + FREE_W;
    localparam int OUT_SPEC   = OUT_CANACC + 1;
    localparam int OUT_END    = OUT_SPEC + 1;

    localparam logic [MODE_W-1:0] MODE_SELECT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WAKE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SPEC   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REVERT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FLUSH  = 3'd5;

    localparam logic [1:0] ST_INVALID = 2'd0;
    localparam logic [1:0] ST_ONE     = 2'd1;
    localparam logic [1:0] ST_TWO     = 2'd2;

    localparam logic [PART_W-1:0] PART_WHOLE = 2'd0;
    localparam logic [PART_W-1:0] PART_ADDR  = 2'd1;
    localparam logic [PART_W-1:0] PART_DATA  = 2'd2;

    typedef struct packed {
        logic [1:0]         state;
        logic [ROB_W-1:0]   rob;
        logic [TAG_W-1:0]   src_a;
        logic [TAG_W-1:0]   src_b;
        logic [TAG_W-1:0]   src_c;
        logic [FU_W-1:0]    fu;
        logic [ITYPE_W-1:0] int_types;
        logic [RDY_W-1:0]   ready;
        logic [1:0]         poison;
    } entry_t;

    // entry handed down to the next lower cell
    typedef struct packed {
        entry_t entry;
        logic   wbv;
    } link_t;

    // prefix terms rippling up from slot 0
    typedef struct packed {
        logic shamt;
        logic taken;
    } chain_t;

    typedef struct packed {
        logic              step_en;
        logic [MODE_W-1:0] mode;
        logic [PORT_W-1:0] port_mask;
        logic [TAG_W-1:0]  wake_tag;
    } ctl_t;

    typedef struct packed {
        logic              hit;
        logic [ROB_W-1:0]  rob;
        logic [TAG_W-1:0]  src_a;
        logic [TAG_W-1:0]  src_b;
        logic [PART_W-1:0] part;
    } gnt_t;

endpackage

@@ rtl/ciq_cell.sv @@
`timescale 1ns / 1ps

module ciq_cell import ciq_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  ctl_t   ctl,
    input  link_t  above_i,
    output link_t  below_o,
    input  chain_t chain_i,
    output chain_t chain_o,
    output gnt_t   gnt_o,
    output logic   free_o,
    output logic   spec_o
);

    entry_t            cur_reg;
    entry_t            cur_next;
    entry_t            mod;
    logic              valid;
    logic              req;
    logic              cand;
    logic              hit;
    logic              partial;
    logic              whole;
    logic              wbv;
    logic              recv;
    logic [PART_W-1:0] part;

    always_comb begin
        valid = (cur_reg.state != ST_INVALID);
        req   = ((cur_reg.state == ST_ONE) && (cur_reg.ready == 4'hF)) ||
                ((cur_reg.state == ST_TWO) && cur_reg.ready[3] &&
                 (cur_reg.ready[0] || cur_reg.ready[1]));
        cand  = (ctl.mode == MODE_SELECT) && req &&
                ((cur_reg.fu & ctl.port_mask) != '0);
        hit   = cand && !chain_i.taken;
        partial = hit && (cur_reg.state == ST_TWO) &&
                  !(cur_reg.ready[0] && cur_reg.ready[1] && cur_reg.ready[3]);
        whole = hit && !partial;

        // two-part store: address half first if its source is ready
        mod  = cur_reg;
        part = PART_WHOLE;
        if (partial) begin
            mod.state = ST_ONE;
            if (cur_reg.ready[0]) begin
                part = PART_ADDR;
                mod.int_types[0] = 1'b0;
            end else begin
                part = PART_DATA;
                mod.int_types[1] = 1'b0;
            end
        end

        wbv           = valid && !whole;
        chain_o.shamt = chain_i.shamt || !valid;
        chain_o.taken = chain_i.taken || cand;
        recv          = chain_o.shamt && above_i.wbv;

        below_o.entry = mod;
        below_o.wbv   = wbv;

        gnt_o.hit   = hit;
        gnt_o.rob   = cur_reg.rob;
        gnt_o.src_a = cur_reg.src_a;
        gnt_o.src_b = cur_reg.src_b;
        gnt_o.part  = part;

        cur_next = cur_reg;
        spec_o   = 1'b0;
        case (ctl.mode)
            MODE_SELECT: begin
                if (recv) begin
                    cur_next = above_i.entry;
                end else if (chain_i.shamt || whole) begin
                    cur_next       = mod;
                    cur_next.state = ST_INVALID;
                end else begin
                    cur_next = mod;
                end
            end
            MODE_WAKE: begin
                if (valid) begin
                    if (cur_reg.src_a == ctl.wake_tag) cur_next.ready[0] = 1'b1;
                    if (cur_reg.src_b == ctl.wake_tag) cur_next.ready[1] = 1'b1;
                    if (cur_reg.src_c == ctl.wake_tag) cur_next.ready[2] = 1'b1;
                end
            end
            MODE_SPEC: begin
                // only integer sources take a speculative wakeup
                if (valid) begin
                    if ((cur_reg.src_a == ctl.wake_tag) && cur_reg.int_types[0]) begin
                        cur_next.ready[0]  = 1'b1;
                        cur_next.poison[0] = 1'b1;
                        spec_o             = 1'b1;
                    end
                    if ((cur_reg.src_b == ctl.wake_tag) && cur_reg.int_types[1]) begin
                        cur_next.ready[1]  = 1'b1;
                        cur_next.poison[1] = 1'b1;
                        spec_o             = 1'b1;
                    end
                end
            end
            MODE_CLEAR: begin
                cur_next.poison = 2'b00;
            end
            MODE_REVERT: begin
                cur_next.ready  = cur_reg.ready & ~{2'b00, cur_reg.poison};
                cur_next.poison = 2'b00;
            end
            MODE_FLUSH: begin
                cur_next.state = ST_INVALID;
            end
            default: begin
            end
        endcase

        if (ctl.mode == MODE_SELECT) begin
            free_o = (!wbv || chain_i.shamt) && !recv;
        end else begin
            free_o = (cur_next.state == ST_INVALID);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg <= '0;
        end else if (ctl.step_en) begin
            cur_reg <= cur_next;
        end
    end

endmodule

@@ rtl/collapsing_issue_queue.sv @@
`timescale 1ns / 1ps

// Collapsing issue queue, eight slots kept oldest first in a row of cells.
// Slave channel: one beat per command; tuser carries the mode (select and
// dispatch, wake, speculative wake, poison clear, poison revert, flush) and
// tdata the port mask, the dispatched entry and the wake tag.
// Master channel: one result beat per command with the grant (slot, ROB tag,
// two source tags, which half of a two-part store), the free count and the
// speculative match flag.
// Each command is applied to the slots in the cycle its beat is taken; the
// result beat shows up in the following cycle from the output register.
// Throughput is one command per cycle while results are taken. The grant priority
// and the collapse shift both ripple through the cell row combinationally.
// A result held by a stalled receiver stays in the output register and the
// slave side is backpressured until it is taken; tready is high whenever the
// output register is empty or is being drained in the same cycle.
// Reset (aresetn low, synchronous) empties every slot and drops any pending
// result; the queue takes commands from the first cycle after reset.
module collapsing_issue_queue import ciq_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // port_mask, dispatch_valid, entry_rob, entry_src_a, entry_src_b, entry_src_c,
    // entry_ready, entry_fu, entry_split, entry_int_types, wake_tag, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // mode
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // grant_valid, grant_index, grant_rob, grant_src_a, grant_src_b, grant_part,
    // free_slots, can_accept, spec_matched, zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    ctl_t                  ctl;
    link_t                 link_w  [SLOTS+1];
    chain_t                chain_w [SLOTS+1];
    gnt_t                  gnt_w   [SLOTS];
    logic [SLOTS-1:0]      free_w;
    logic [SLOTS-1:0]      spec_w;

    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic [M_TDATA_W-1:0]  m_tdata_next;

    logic                  g_valid;
    logic [SLOT_IDX_W-1:0] g_slot;
    logic [ROB_W-1:0]      g_rob;
    logic [TAG_W-1:0]      g_src_a;
    logic [TAG_W-1:0]      g_src_b;
    logic [PART_W-1:0]     g_part;
    logic [CNT_W-1:0]      free_cnt;

    assign s_tready = !m_tvalid_reg || m_tready;

    assign ctl.step_en   = s_tvalid && s_tready;
    assign ctl.mode      = s_tuser;
    assign ctl.port_mask = s_tdata[IN_PORT +: PORT_W];
    assign ctl.wake_tag  = s_tdata[IN_WTAG +: TAG_W];

    // the dispatched entry sits above the top cell
    always_comb begin
        link_w[SLOTS].wbv             = s_tdata[IN_DISP];
        link_w[SLOTS].entry.state     = s_tdata[IN_SPLIT] ? ST_TWO : ST_ONE;
        link_w[SLOTS].entry.rob       = s_tdata[IN_ROB +: ROB_W];
        link_w[SLOTS].entry.src_a     = s_tdata[IN_SRC_A +: TAG_W];
        link_w[SLOTS].entry.src_b     = s_tdata[IN_SRC_B +: TAG_W];
        link_w[SLOTS].entry.src_c     = s_tdata[IN_SRC_C +: TAG_W];
        link_w[SLOTS].entry.fu        = s_tdata[IN_FU +: FU_W];
        link_w[SLOTS].entry.int_types = s_tdata[IN_ITYPE +: ITYPE_W];
        link_w[SLOTS].entry.ready     = s_tdata[IN_RDY +: RDY_W];
        link_w[SLOTS].entry.poison    = 2'b00;
    end

    assign chain_w[0].shamt = 1'b0;
    assign chain_w[0].taken = 1'b0;

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        ciq_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .above_i (link_w[i+1]),
            .below_o (link_w[i]),
            .chain_i (chain_w[i]),
            .chain_o (chain_w[i+1]),
            .gnt_o   (gnt_w[i]),
            .free_o  (free_w[i]),
            .spec_o  (spec_w[i])
        );
    end

    // at most one cell hits, so an AND-OR mux picks the grant
    always_comb begin
        g_valid = 1'b0;
        g_slot  = '0;
        g_rob   = '0;
        g_src_a = '0;
        g_src_b = '0;
        g_part  = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (gnt_w[i].hit) begin
                g_valid = 1'b1;
                g_slot  = g_slot | SLOT_IDX_W'(i);
                g_rob   = g_rob | gnt_w[i].rob;
                g_src_a = g_src_a | gnt_w[i].src_a;
                g_src_b = g_src_b | gnt_w[i].src_b;
                g_part  = g_part | gnt_w[i].part;
            end
        end
        free_cnt = CNT_W'($countones(free_w));

        m_tdata_next                         = '0;
        m_tdata_next[OUT_GVALID]             = g_valid;
        m_tdata_next[OUT_GSLOT +: GSLOT_W]   = GSLOT_W'(g_slot);
        m_tdata_next[OUT_GROB +: ROB_W]      = g_rob;
        m_tdata_next[OUT_GSRC_A +: TAG_W]    = g_src_a;
        m_tdata_next[OUT_GSRC_B +: TAG_W]    = g_src_b;
        m_tdata_next[OUT_GPART +: PART_W]    = g_part;
        m_tdata_next[OUT_FREE +: FREE_W]     = FREE_W'(free_cnt);
        m_tdata_next[OUT_CANACC]             = (free_cnt != '0);
        m_tdata_next[OUT_SPEC]               = |spec_w;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.step_en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ rtl/ciq_checker.sv @@
`timescale 1ns / 1ps

module ciq_checker import ciq_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // every accepted command leaves a result beat behind
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted command produced no result");

    a_can_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_CANACC] == (m_tdata[OUT_FREE +: FREE_W] != '0)))
        else $error("can_accept disagrees with free count");

    a_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[OUT_GVALID] |->
            (m_tdata[OUT_GSLOT +: GSLOT_W] == '0) && (m_tdata[OUT_GROB +: ROB_W] == '0) &&
            (m_tdata[OUT_GPART +: PART_W] == PART_WHOLE))
        else $error("grant fields set without a grant");

    a_free_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_FREE +: FREE_W] <= FREE_W'(SLOTS)) &&
            (m_tdata[OUT_GPART +: PART_W] != 2'd3))
        else $error("free count or grant half out of range");

endmodule

bind collapsing_issue_queue ciq_checker u_ciq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
